@@ src/fvnh_pkg.sv @@
// Shared types, constants and widths for the fractal value-noise height block.
// Depends on nothing; every other file of the block uses it.
package fvnh_pkg;

  localparam int MAX_OCTAVES_DEF = 8;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

  localparam logic [31:0] DEF_FREQ = 32'd167772;
  localparam logic [15:0] DEF_PERS = 16'd2048;
  localparam logic [15:0] DEF_LAC  = 16'd8192;
  localparam logic [3:0]  DEF_OCT  = 4'd4;
  localparam logic [23:0] DEF_GAIN = 24'd25600;
  localparam logic [31:0] AMP_ONE  = 32'd65536;

  localparam int COORD_W   = 24;
  localparam int HEIGHT_W  = 25;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Fixed to cover the largest octave count the block supports (16).
  localparam int TOTAL_W = 36;
  localparam int WGT_W   = 50;
  localparam int SUM_W   = 54;
  localparam int MAG_W   = 54;
  localparam int QUO_W   = 16;

  localparam int LANE_LAT   = 10;
  localparam int DIV_STAGES = QUO_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED = 3'd0,
    REG_FREQ = 3'd1,
    REG_PERS = 3'd2,
    REG_LAC  = 3'd3,
    REG_OCT  = 3'd4,
    REG_GAIN = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               busy;
    logic [23:0]        gain;
    logic [TOTAL_W-1:0] total;
  } cfg_stat_t;

endpackage

@@ src/fvnh_if.sv @@
// Handshake channel interfaces for the fractal value-noise height block.
// Depends on fvnh_pkg for the field widths.
interface fvnh_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fvnh_pkg::COORD_W-1:0]  coord_x;
  logic signed [fvnh_pkg::COORD_W-1:0]  coord_z;
  modport source (output valid, output coord_x, output coord_z, input ready);
  modport sink (input valid, input coord_x, input coord_z, output ready);
endinterface

interface fvnh_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fvnh_pkg::HEIGHT_W-1:0] terrain_height;
  modport source (output valid, output terrain_height, input ready);
  modport sink (input valid, input terrain_height, output ready);
endinterface

interface fvnh_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [fvnh_pkg::CFG_IDX_W-1:0]       index;
  logic [fvnh_pkg::CFG_DAT_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/fvnh_cfg.sv @@
// Configuration registers and the octave table sequencer.
// Depends on fvnh_pkg and the fvnh_cfg_if interface.
module fvnh_cfg #(
  parameter int MaxOctaves = fvnh_pkg::MAX_OCTAVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fvnh_cfg_if.sink              cfg,
  output logic [31:0]           freq_tab [MaxOctaves],
  output logic [31:0]           amp_tab  [MaxOctaves],
  output logic [31:0]           seed_tab [MaxOctaves],
  output fvnh_pkg::cfg_stat_t   stat
);
  import fvnh_pkg::*;

  localparam int KW = (MaxOctaves > 1) ? $clog2(MaxOctaves) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(MaxOctaves - 1);
  localparam logic [4:0] N_MAX = 5'(MaxOctaves);

  logic [31:0] seed_r, freq_r, cur_freq_r, cur_amp_r;
  logic [15:0] pers_r, lac_r;
  logic [3:0]  oct_r;
  logic [23:0] gain_r;
  logic        start_r, busy_r;
  logic [KW-1:0] k_r;
  logic [TOTAL_W-1:0] total_r;

  logic [31:0] freq_eff;
  logic [15:0] pers_eff, lac_eff;
  logic [4:0]  n_eff;
  logic [23:0] gain_eff;
  logic [47:0] fprod, aprod;
  logic [31:0] freq_nxt, amp_nxt, amp_use;
  logic        wr;

  assign wr  = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    freq_eff = (freq_r != '0) ? freq_r : DEF_FREQ;
    pers_eff = (pers_r != '0) ? pers_r : DEF_PERS;
    lac_eff  = (lac_r  != '0) ? lac_r  : DEF_LAC;
    gain_eff = (gain_r != '0) ? gain_r : DEF_GAIN;
    n_eff    = (oct_r  != '0) ? {1'b0, oct_r} : {1'b0, DEF_OCT};
    if (n_eff > N_MAX) begin
      n_eff = N_MAX;
    end
    fprod    = {16'b0, cur_freq_r} * {32'b0, lac_eff};
    aprod    = {16'b0, cur_amp_r} * {32'b0, pers_eff};
    freq_nxt = (fprod[47:44] != '0) ? 32'hFFFF_FFFF : fprod[43:12];
    amp_nxt  = (aprod[47:44] != '0) ? 32'hFFFF_FFFF : aprod[43:12];
    amp_use  = (5'(k_r) < n_eff) ? cur_amp_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= '0;
      freq_r  <= DEF_FREQ;
      pers_r  <= DEF_PERS;
      lac_r   <= DEF_LAC;
      oct_r   <= DEF_OCT;
      gain_r  <= DEF_GAIN;
      start_r <= 1'b1;
      busy_r  <= 1'b1;
      k_r     <= '0;
      total_r <= '0;
    end else if (wr) begin
      case (cfg.index)
        REG_SEED: seed_r <= cfg.data;
        REG_FREQ: freq_r <= cfg.data;
        REG_PERS: pers_r <= cfg.data[15:0];
        REG_LAC:  lac_r  <= cfg.data[15:0];
        REG_OCT:  oct_r  <= cfg.data[3:0];
        REG_GAIN: gain_r <= cfg.data[23:0];
        default: ;
      endcase
      start_r <= 1'b1;
      busy_r  <= 1'b1;
    end else if (start_r) begin
      start_r <= 1'b0;
      k_r     <= '0;
      total_r <= '0;
    end else if (busy_r) begin
      total_r <= total_r + TOTAL_W'(amp_use);
      k_r     <= k_r + 1'b1;
      if (k_r == K_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_r) begin
      cur_freq_r <= freq_eff;
      cur_amp_r  <= AMP_ONE;
    end else if (busy_r) begin
      freq_tab[k_r] <= cur_freq_r;
      amp_tab[k_r]  <= amp_use;
      seed_tab[k_r] <= seed_r + 32'(k_r);
      cur_freq_r    <= freq_nxt;
      cur_amp_r     <= amp_nxt;
    end
  end

  assign stat.busy  = busy_r || start_r;
  assign stat.gain  = gain_eff;
  assign stat.total = total_r;

endmodule

@@ src/fvnh_octave.sv @@
// One octave lane: scales the point, hashes four lattice corners, blends them
// and weights the result. Depends on fvnh_pkg.
module fvnh_octave (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [fvnh_pkg::COORD_W-1:0] x,
  input  logic signed [fvnh_pkg::COORD_W-1:0] z,
  input  logic [31:0]                         seed,
  input  logic [31:0]                         freq,
  input  logic [31:0]                         amp,
  output logic signed [fvnh_pkg::WGT_W-1:0]   wgt
);
  import fvnh_pkg::*;

  logic signed [56:0] px, pz;
  logic [31:0] ix_r, iz_r;
  logic [15:0] fx_r, fz_r;

  logic [63:0] pa, pb;
  logic [31:0] sqx, sqz;
  logic [31:0] a_r, b_r;
  logic [15:0] fx2_r, fz2_r;
  logic [17:0] tx_r, tz_r;

  logic [33:0] wxp, wzp;
  logic [31:0] h [4];
  logic [31:0] hm_r [4];
  logic [16:0] wu3_r, wv3_r;

  logic [63:0] mix [4];
  logic [31:0] hh_r [4];
  logic [16:0] wu4_r, wv4_r;

  logic signed [15:0] g_r [4];
  logic [16:0] wu5_r, wv5_r;

  logic signed [16:0] d0, d1;
  logic signed [34:0] p0_r, p1_r;
  logic signed [15:0] g00_r, g01_r;
  logic [16:0] wv6_r;

  logic signed [16:0] ea_r, eb_r;
  logic [16:0] wv7_r;

  logic signed [17:0] d2;
  logic signed [35:0] p2_r;
  logic signed [16:0] ea8_r;

  logic signed [16:0] n_r;

  assign px = x * $signed({1'b0, freq});
  assign pz = z * $signed({1'b0, freq});
  assign pa = {32'b0, ix_r} * {32'b0, HASH_MUL_X};
  assign pb = {32'b0, iz_r} * {32'b0, HASH_MUL_Z};
  assign sqx = {16'b0, fx_r} * {16'b0, fx_r};
  assign sqz = {16'b0, fz_r} * {16'b0, fz_r};
  assign wxp = {18'b0, fx2_r} * {16'b0, tx_r};
  assign wzp = {18'b0, fz2_r} * {16'b0, tz_r};

  // Corner order: (x,z), (x+1,z), (x,z+1), (x+1,z+1).
  always_comb begin
    h[0] = seed + a_r + b_r;
    h[1] = seed + a_r + b_r + HASH_MUL_X;
    h[2] = seed + a_r + b_r + HASH_MUL_Z;
    h[3] = seed + a_r + b_r + HASH_MUL_X + HASH_MUL_Z;
    for (int k = 0; k < 4; k++) begin
      mix[k] = {32'b0, hm_r[k]} * {32'b0, HASH_MUL_MIX};
    end
  end

  assign d0 = 17'(g_r[1]) - 17'(g_r[0]);
  assign d1 = 17'(g_r[3]) - 17'(g_r[2]);
  assign d2 = 18'(eb_r) - 18'(ea_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ix_r  <= px[55:24];
      iz_r  <= pz[55:24];
      fx_r  <= px[23:8];
      fz_r  <= pz[23:8];

      a_r   <= pa[31:0];
      b_r   <= pb[31:0];
      fx2_r <= sqx[31:16];
      fz2_r <= sqz[31:16];
      tx_r  <= 18'd196608 - {1'b0, fx_r, 1'b0};
      tz_r  <= 18'd196608 - {1'b0, fz_r, 1'b0};

      for (int k = 0; k < 4; k++) begin
        hm_r[k] <= h[k] ^ (h[k] >> 13);
        hh_r[k] <= mix[k][31:0];
        // The folded hash (low half XOR high half) minus 32768 is that value with its top bit flipped.
        g_r[k]  <= $signed((hh_r[k][15:0] ^ hh_r[k][31:16]) ^ 16'h8000);
      end
      wu3_r <= wxp[32:16];
      wv3_r <= wzp[32:16];
      wu4_r <= wu3_r;
      wv4_r <= wv3_r;
      wu5_r <= wu4_r;
      wv5_r <= wv4_r;

      p0_r  <= d0 * $signed({1'b0, wu5_r});
      p1_r  <= d1 * $signed({1'b0, wu5_r});
      g00_r <= g_r[0];
      g01_r <= g_r[2];
      wv6_r <= wv5_r;

      ea_r  <= 17'(g00_r) + p0_r[32:16];
      eb_r  <= 17'(g01_r) + p1_r[32:16];
      wv7_r <= wv6_r;

      p2_r  <= d2 * $signed({1'b0, wv7_r});
      ea8_r <= ea_r;

      n_r   <= ea8_r + p2_r[32:16];

      wgt   <= n_r * $signed({1'b0, amp});
    end
  end

endmodule

@@ src/fvnh_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, for the weight
// normalization. Depends on fvnh_pkg.
module fvnh_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [fvnh_pkg::MAG_W-1:0]       mag,
  input  logic                             neg,
  input  logic [fvnh_pkg::TOTAL_W-1:0]     total,
  output logic [fvnh_pkg::QUO_W-1:0]       quo,
  output logic                             quo_neg
);
  import fvnh_pkg::*;

  logic [MAG_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] q_r   [DIV_STAGES];
  logic             neg_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam int B = DIV_STAGES - 1 - s;
    logic [MAG_W-1:0] rem_in, dsh;
    logic [QUO_W-1:0] q_in;
    logic             neg_in;

    if (s == 0) begin : g_first
      assign rem_in = mag;
      assign q_in   = '0;
      assign neg_in = neg;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign q_in   = q_r[s-1];
      assign neg_in = neg_r[s-1];
    end

    assign dsh = MAG_W'(total) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= dsh) begin
          rem_r[s] <= rem_in - dsh;
          q_r[s]   <= q_in | (QUO_W'(1) << B);
        end else begin
          rem_r[s] <= rem_in;
          q_r[s]   <= q_in;
        end
        neg_r[s] <= neg_in;
      end
    end
  end

  assign quo     = q_r[DIV_STAGES-1];
  assign quo_neg = neg_r[DIV_STAGES-1];

endmodule

@@ src/fractal_value_noise_height.sv @@
// Top level of the fractal value-noise terrain height block.
// Depends on fvnh_pkg, the channel interfaces, fvnh_cfg, fvnh_octave and fvnh_div.
//
// Each input beat on in_ch carries one integer world point (coord_x, coord_z);
// each output beat on out_ch carries its signed Q16.8 terrain_height. The
// cfg_ch channel writes one of six registers per beat (seed, base frequency,
// persistence, lacunarity, octave count, height gain); indexes above five are
// ignored. Configuration is meant to be written while no point is in flight.
//
// All octaves are evaluated side by side in parallel lanes of ten stages each,
// summed by a registered adder tree, normalized by a sixteen-stage restoring
// divider and scaled by the gain. A new point is taken every cycle while the
// pipeline is not held and the sequencer is idle; each result is presented
// once its point has passed the input register, the lanes, the adder tree, the
// magnitude register, the divider and the gain and output registers.
//
// After reset and after every configuration beat, a sequencer rebuilds the
// per-octave frequency, amplitude and seed tables, one octave per cycle; while
// it runs, in_ch.ready stays low. When the receiver holds
// out_ch.ready low with a result waiting, the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated.
module fractal_value_noise_height #(
  parameter int MaxOctaves = fvnh_pkg::MAX_OCTAVES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fvnh_in_if.sink   in_ch,
  fvnh_out_if.source out_ch,
  fvnh_cfg_if.sink  cfg_ch
);
  import fvnh_pkg::*;

  localparam int LVL   = (MaxOctaves > 1) ? $clog2(MaxOctaves) : 0;
  localparam int LEAVES = 1 << LVL;
  localparam int LV    = (LVL == 0) ? 1 : LVL;
  localparam int DEPTH = 1 + LANE_LAT + LVL + 1 + DIV_STAGES + 2;

  logic [31:0] freq_tab [MaxOctaves];
  logic [31:0] amp_tab  [MaxOctaves];
  logic [31:0] seed_tab [MaxOctaves];
  cfg_stat_t   stat;

  logic en;
  logic [DEPTH-1:0] vld_r;

  logic signed [COORD_W-1:0] x_r, z_r;

  logic signed [WGT_W-1:0] wgt  [MaxOctaves];
  logic signed [SUM_W-1:0] leaf [LEAVES];
  logic signed [SUM_W-1:0] tree_r [1:LV][LEAVES];
  logic signed [SUM_W-1:0] sum;

  logic [MAG_W-1:0] mag_r;
  logic             neg_r;

  logic [QUO_W-1:0] quo;
  logic             quo_neg;
  logic signed [QUO_W:0] ratio;
  logic signed [41:0] prod_r;
  logic signed [26:0] hsh;
  logic signed [HEIGHT_W-1:0] height_nxt, height_r;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en && !stat.busy;

  fvnh_cfg #(.MaxOctaves(MaxOctaves)) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_ch),
    .freq_tab (freq_tab),
    .amp_tab  (amp_tab),
    .seed_tab (seed_tab),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid && in_ch.ready};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= in_ch.coord_x;
      z_r <= in_ch.coord_z;
    end
  end

  for (genvar i = 0; i < MaxOctaves; i++) begin : g_lane
    fvnh_octave u_oct (
      .clk  (clk),
      .en   (en),
      .x    (x_r),
      .z    (z_r),
      .seed (seed_tab[i]),
      .freq (freq_tab[i]),
      .amp  (amp_tab[i]),
      .wgt  (wgt[i])
    );
  end

  // Unused octaves carry a zero amplitude, so they add nothing to the sum.
  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < MaxOctaves) begin : g_used
      assign leaf[j] = SUM_W'(wgt[j]);
    end else begin : g_pad
      assign leaf[j] = '0;
    end
  end

  for (genvar l = 1; l <= LVL; l++) begin : g_lvl
    for (genvar j = 0; j < (LEAVES >> l); j++) begin : g_node
      if (l == 1) begin : g_from_leaf
        always_ff @(posedge clk) begin
          if (en) begin
            tree_r[l][j] <= leaf[2*j] + leaf[2*j+1];
          end
        end
      end else begin : g_from_node
        always_ff @(posedge clk) begin
          if (en) begin
            tree_r[l][j] <= tree_r[l-1][2*j] + tree_r[l-1][2*j+1];
          end
        end
      end
    end
  end

  if (LVL == 0) begin : g_no_tree
    assign sum = leaf[0];
  end else begin : g_tree
    assign sum = tree_r[LV][0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
      neg_r <= sum[SUM_W-1];
    end
  end

  fvnh_div u_div (
    .clk     (clk),
    .en      (en),
    .mag     (mag_r),
    .neg     (neg_r),
    .total   (stat.total),
    .quo     (quo),
    .quo_neg (quo_neg)
  );

  // Quotient truncates toward zero; the gain product then floors.
  assign ratio = quo_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign hsh   = prod_r[41:15];

  always_comb begin
    if (hsh > 27'sd16777215) begin
      height_nxt = 25'sh0FFFFFF;
    end else if (hsh < -27'sd16777216) begin
      height_nxt = 25'sh1000000;
    end else begin
      height_nxt = hsh[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= 42'(ratio * $signed({1'b0, stat.gain}));
      height_r <= height_nxt;
    end
  end

  assign out_ch.valid          = vld_r[DEPTH-1];
  assign out_ch.terrain_height = height_r;

endmodule
